// ===== design/arpc_pkg.sv =====
// Shared types and constants for the ARP cache responder.
package arpc_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int OP_W  = 16;
    localparam int ROW_W = IP_W + MAC_W;

    localparam logic [OP_W-1:0] OP_REQUEST = 16'h0001;
    localparam logic [OP_W-1:0] OP_REPLY   = 16'h0002;

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic CFG_LOCAL_IP = 1'b0;

    // broadcast pair held in entry 0 after reset
    localparam logic [IP_W-1:0]  BCAST_IP  = {(IP_W/8){8'hff}};
    localparam logic [MAC_W-1:0] BCAST_MAC = {(MAC_W/8){8'hff}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;  // latch the input word, restart the scan
        logic read;     // fetch the row at the scan index
        logic advance;  // step the scan index
        logic resolve;  // close the scan; a packet with a valid opcode learns on a miss
        logic load;     // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic match;    // fetched row matches the search key
        logic last;     // scan index is on the final entry
        logic out_free; // output register can take a result this cycle
    } status_t;

endpackage

// ===== design/arpc_ctrl.sv =====
// Sequencer for the ARP cache scan: accept, fetch/compare per entry, result hand-off.
module arpc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  arpc_pkg::status_t sts_i,
    output arpc_pkg::cmd_t    cmd_o
);
    import arpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.capture = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd_o.read = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts_i.match || sts_i.last) begin
                    cmd_o.resolve = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    cmd_o.advance = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_FINISH: begin
                if (sts_i.out_free) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd_o.capture, cmd_o.read, cmd_o.advance, cmd_o.resolve, cmd_o.load}))
        else $error("more than one datapath command at once");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.load |-> sts_i.out_free)
        else $error("result loaded over a word still waiting");
    a_read_then_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.read |=> (cmd_o.resolve || cmd_o.advance))
        else $error("fetched row not compared in the next cycle");
`endif

endmodule

// ===== design/arpc_datapath.sv =====
// Cache table, scan compare, learning write and output register.
module arpc_datapath #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [arpc_pkg::MAC_W-1:0]  cfg_wdata,
    input  logic                        s_action,
    input  logic [arpc_pkg::OP_W-1:0]   s_opcode,
    input  logic [arpc_pkg::MAC_W-1:0]  s_sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]   s_sender_ip,
    input  logic [arpc_pkg::IP_W-1:0]   s_target_ip,
    input  logic [arpc_pkg::IP_W-1:0]   s_query_ip,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic                        m_send_reply,
    output logic [arpc_pkg::MAC_W-1:0]  m_reply_mac,
    output logic [arpc_pkg::IP_W-1:0]   m_reply_ip,
    output logic                        m_learned,
    output logic                        m_lookup_hit,
    output logic [arpc_pkg::MAC_W-1:0]  m_lookup_mac,
    input  arpc_pkg::cmd_t              cmd_i,
    output arpc_pkg::status_t           sts_o
);
    import arpc_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] WP_RESET = IDX_W'(1);

    // table storage plus per-entry valid bits (invalid rows read as reset value)
    logic [ROW_W-1:0]   mem_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   wp_reg;

    logic [IP_W-1:0]    local_ip_reg;

    // captured input word
    logic               action_reg;
    logic [OP_W-1:0]    opcode_reg;
    logic [MAC_W-1:0]   smac_reg;
    logic [IP_W-1:0]    sip_reg;
    logic [IP_W-1:0]    tip_reg;
    logic [IP_W-1:0]    key_reg;

    // scan state
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [ROW_W-1:0]   rd_row_reg;
    logic               rd_vld_reg;
    logic               hit_reg;
    logic [MAC_W-1:0]   hit_mac_reg;
    logic               learned_reg;

    // output register
    logic               m_valid_reg;
    logic               send_reply_reg;
    logic [MAC_W-1:0]   reply_mac_reg;
    logic [IP_W-1:0]    reply_ip_reg;
    logic               learned_out_reg;
    logic               lookup_hit_reg;
    logic [MAC_W-1:0]   lookup_mac_reg;

    logic [IP_W-1:0]    eff_ip;
    logic [MAC_W-1:0]   eff_mac;
    logic               is_pkt;
    logic               op_ok;
    logic               do_reply;
    logic               do_learn;

    always_comb begin
        if (rd_vld_reg) begin
            eff_ip  = rd_row_reg[ROW_W-1:MAC_W];
            eff_mac = rd_row_reg[MAC_W-1:0];
        end else if (scan_idx_reg == '0) begin
            eff_ip  = BCAST_IP;
            eff_mac = BCAST_MAC;
        end else begin
            eff_ip  = '0;
            eff_mac = '0;
        end
    end

    assign is_pkt   = (action_reg == ACT_PACKET);
    assign op_ok    = (opcode_reg == OP_REQUEST) || (opcode_reg == OP_REPLY);
    assign do_reply = is_pkt && (opcode_reg == OP_REQUEST) && (tip_reg == local_ip_reg);
    assign do_learn = cmd_i.resolve && !sts_o.match && is_pkt && op_ok;

    assign sts_o.match    = (eff_ip == key_reg);
    assign sts_o.last     = (scan_idx_reg == LAST_IDX);
    assign sts_o.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg <= '0;
        end else if (cfg_wr_en && (cfg_index == CFG_LOCAL_IP)) begin
            local_ip_reg <= cfg_wdata[IP_W-1:0];
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_learn) begin
            mem_reg[wp_reg] <= {sip_reg, smac_reg};
        end
        if (cmd_i.read) begin
            rd_row_reg <= mem_reg[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            wp_reg    <= WP_RESET;
        end else if (do_learn) begin
            valid_reg[wp_reg] <= 1'b1;
            wp_reg            <= (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            action_reg   <= s_action;
            opcode_reg   <= s_opcode;
            smac_reg     <= s_sender_mac;
            sip_reg      <= s_sender_ip;
            tip_reg      <= s_target_ip;
            key_reg      <= (s_action == ACT_PACKET) ? s_sender_ip : s_query_ip;
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
            learned_reg  <= 1'b0;
        end else if (cmd_i.advance) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end else if (cmd_i.resolve) begin
            hit_reg     <= sts_o.match;
            hit_mac_reg <= eff_mac;
            learned_reg <= do_learn;
        end
        if (cmd_i.read) begin
            rd_vld_reg <= valid_reg[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            send_reply_reg  <= do_reply;
            reply_mac_reg   <= do_reply ? smac_reg : '0;
            reply_ip_reg    <= do_reply ? sip_reg : '0;
            learned_out_reg <= learned_reg;
            lookup_hit_reg  <= !is_pkt && hit_reg;
            lookup_mac_reg  <= (!is_pkt && hit_reg) ? hit_mac_reg : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_send_reply = send_reply_reg;
    assign m_reply_mac  = reply_mac_reg;
    assign m_reply_ip   = reply_ip_reg;
    assign m_learned    = learned_out_reg;
    assign m_lookup_hit = lookup_hit_reg;
    assign m_lookup_mac = lookup_mac_reg;

`ifndef SYNTH
    a_wp_only_on_learn: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_learn |=> $stable(wp_reg))
        else $error("write pointer moved without a learning write");
    a_learn_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        do_learn |=> valid_reg[$past(wp_reg)])
        else $error("learned entry not marked valid");
    a_hit_recorded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.resolve && sts_o.match) |=> (hit_reg && !learned_reg))
        else $error("scan hit not recorded or hit entry relearned");
`endif

endmodule

// ===== design/arp_cache_responder.sv =====
// Top level of the ARP cache responder: sequencer plus table datapath.
// Scan: after a word is taken the sequencer reads k table rows (1..ENTRIES), one per
//   fetch/compare pair, up to the first match or the end, then waits in ST_FINISH until
//   the output register is free and loads the result. A new word is taken only once the
//   result is loaded; the scan uses the table's one registered read port.
// Reset (aresetn, synchronous, active low): valid bits cleared so entry 0 reads as the
//   broadcast pair and others as zero, write pointer 1, local_ip 0; no clearing sweep.
module arp_cache_responder #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration writes: index 0 local_ip; index 1 (local_mac) is not stored
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [arpc_pkg::MAC_W-1:0]  cfg_wdata,
    // input words: received ARP packet or lookup query
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [arpc_pkg::OP_W-1:0]   s_opcode,
    input  logic [arpc_pkg::MAC_W-1:0]  s_sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]   s_sender_ip,
    input  logic [arpc_pkg::IP_W-1:0]   s_target_ip,
    input  logic [arpc_pkg::IP_W-1:0]   s_query_ip,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_send_reply,
    output logic [arpc_pkg::MAC_W-1:0]  m_reply_mac,
    output logic [arpc_pkg::IP_W-1:0]   m_reply_ip,
    output logic                        m_learned,
    output logic                        m_lookup_hit,
    output logic [arpc_pkg::MAC_W-1:0]  m_lookup_mac
);
    import arpc_pkg::*;

    // local_mac would only source the reply frame's own address, which is built
    // downstream; the block's results never carry it, so no register holds it here.

    cmd_t    cmd;
    status_t sts;

    // Sequencer: takes a word only when idle, then walks the table one row per
    // fetch/compare pair and hands the result to the output register.
    arpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts_i   (sts),
        .cmd_o   (cmd)
    );

    // Datapath: table memory, valid bits, round-robin write pointer, compare,
    // and the output register that lets a new word in while a result waits.
    arpc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_action     (s_action),
        .s_opcode     (s_opcode),
        .s_sender_mac (s_sender_mac),
        .s_sender_ip  (s_sender_ip),
        .s_target_ip  (s_target_ip),
        .s_query_ip   (s_query_ip),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_send_reply (m_send_reply),
        .m_reply_mac  (m_reply_mac),
        .m_reply_ip   (m_reply_ip),
        .m_learned    (m_learned),
        .m_lookup_hit (m_lookup_hit),
        .m_lookup_mac (m_lookup_mac),
        .cmd_i        (cmd),
        .sts_o        (sts)
    );

endmodule
